FILE: hdl/rsnp_pkg.sv
// Shared types, widths and constants for the ray/sphere nearest pick block.
`timescale 1ns / 1ps
package rsnp_pkg;

  localparam int COORD_W       = 32;
  localparam int DIR_W         = 18;
  localparam int RAD_W         = 31;
  localparam int IDX_W         = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam int MAX_SPHERES_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [RAD_W-1:0] DIST_MAX = {RAD_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

  // Ray direction handed from the register file to the back end.
  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } ray_t;

  // One classified sphere waiting in the queue.
  typedef struct packed {
    logic signed [DIFF_W-1:0] tx;
    logic signed [DIFF_W-1:0] ty;
    logic signed [DIFF_W-1:0] tz;
    logic [RAD_W-1:0]         radius;
    logic                     last;
    logic                     skip;
    logic [IDX_W-1:0]         index;
  } job_t;

  // Push side of the queue.
  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

  // Pop side of the queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } qrd_t;

endpackage

FILE: hdl/rsnp_sphere_if.sv
// Sphere input channel: valid/ready with one sphere per item.
`timescale 1ns / 1ps
interface rsnp_sphere_if;
  import rsnp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          sphere_radius;
  logic                      last_sphere;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, last_sphere,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, sphere_radius, last_sphere,
                output ready);
endinterface

FILE: hdl/rsnp_result_if.sv
// Result channel: valid/ready with one pick result per item.
`timescale 1ns / 1ps
interface rsnp_result_if;
  import rsnp_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit_found;
  logic [IDX_W-1:0] nearest_index;
  logic [RAD_W-1:0] nearest_distance;

  modport source (output valid, hit_found, nearest_index, nearest_distance, input ready);
  modport sink (input valid, hit_found, nearest_index, nearest_distance, output ready);
endinterface

FILE: hdl/rsnp_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps
interface rsnp_cfg_if;
  import rsnp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/rsnp_front.sv
// Front end: config registers, sphere accept, offset from eye, run position.
`timescale 1ns / 1ps
module rsnp_front #(
  parameter int MAX_SPHERES = rsnp_pkg::MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = rsnp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  rsnp_cfg_if.sink           cfg,
  rsnp_sphere_if.sink        sphere,
  input  logic               q_ready,
  output rsnp_pkg::qwr_t     q_wr,
  output rsnp_pkg::ray_t     ray
);
  import rsnp_pkg::*;

  localparam int CW = $clog2(MAX_SPHERES + 1);
  localparam logic signed [DIR_W-1:0] DIR_NEG_ONE =
    DIR_W'(-(longint'(1) <<< FRAC_BITS));

  logic signed [COORD_W-1:0] eye_x, eye_y, eye_z;
  logic [CW-1:0]             count;
  logic [31:0]               count_wide;
  logic                      accept;
  logic                      skip;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x     <= '0;
      eye_y     <= '0;
      eye_z     <= '0;
      ray.dir_x <= '0;
      ray.dir_y <= '0;
      ray.dir_z <= DIR_NEG_ONE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EYE_X: eye_x     <= signed'(cfg.data);
        REG_EYE_Y: eye_y     <= signed'(cfg.data);
        REG_EYE_Z: eye_z     <= signed'(cfg.data);
        REG_DIR_X: ray.dir_x <= signed'(cfg.data[DIR_W-1:0]);
        REG_DIR_Y: ray.dir_y <= signed'(cfg.data[DIR_W-1:0]);
        REG_DIR_Z: ray.dir_z <= signed'(cfg.data[DIR_W-1:0]);
        default: ;
      endcase
    end
  end

  assign sphere.ready = q_ready;
  assign accept       = sphere.valid && q_ready;
  assign skip         = (count >= CW'(MAX_SPHERES));
  assign count_wide   = 32'(count);

  // Spheres past the capacity still travel so that the last mark ends the run.
  always_comb begin
    q_wr.push       = accept;
    q_wr.job.tx     = DIFF_W'(sphere.center_x) - DIFF_W'(eye_x);
    q_wr.job.ty     = DIFF_W'(sphere.center_y) - DIFF_W'(eye_y);
    q_wr.job.tz     = DIFF_W'(sphere.center_z) - DIFF_W'(eye_z);
    q_wr.job.radius = sphere.sphere_radius;
    q_wr.job.last   = sphere.last_sphere;
    q_wr.job.skip   = skip;
    q_wr.job.index  = count_wide[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (sphere.last_sphere) begin
        count <= '0;
      end else if (!skip) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/rsnp_queue.sv
// Two-entry queue of classified spheres between front and back ends.
`timescale 1ns / 1ps
module rsnp_queue (
  input  logic           clk,
  input  logic           rst,
  input  rsnp_pkg::qwr_t q_wr,
  output logic           q_ready,
  input  logic           pop,
  output rsnp_pkg::qrd_t q_rd
);
  import rsnp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     fill;
  logic            do_push, do_pop;

  assign q_ready    = (fill != (PW+1)'(QUEUE_DEPTH));
  assign q_rd.valid = (fill != '0);
  assign q_rd.job   = slots[rd_ptr];
  assign do_push    = q_wr.push && q_ready;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

FILE: hdl/rsnp_back.sv
// Back end: per-sphere probe sequencer, bit-pair square root, nearest tracking.
`timescale 1ns / 1ps
module rsnp_back #(
  parameter int FRAC_BITS = rsnp_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rsnp_pkg::ray_t ray,
  input  rsnp_pkg::qrd_t q_rd,
  output logic           pop,
  rsnp_result_if.source  result
);
  import rsnp_pkg::*;

  localparam int PROD_W = DIFF_W + DIR_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int DW     = DOT_W - FRAC_BITS;
  localparam int PJ_W   = DW + DIR_W;
  localparam int WIDE_W = 72;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_PROJ = 4'd3;
  localparam logic [3:0] S_PERP = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]               state;
  job_t                     job;
  logic signed [PROD_W-1:0] m0, m1, m2;
  logic signed [DW-1:0]     axial;
  logic signed [PJ_W-1:0]   p0, p1, p2;
  logic [RAD_W-1:0]         ax, ay, az;
  logic [2*RAD_W-1:0]       s0, s1, s2, rsq;
  logic [63:0]              rem, root, sq_bit;
  logic [4:0]               iter;
  logic                     hit;
  logic [RAD_W-1:0]         entry;

  logic [RAD_W-1:0]         best_distance;
  logic [IDX_W-1:0]         best_position;
  logic                     any_hit;

  logic signed [DOT_W-1:0]  dot;
  logic signed [WIDE_W-1:0] px, py, pz;
  logic [WIDE_W-1:0]        abx, aby, abz;
  logic                     far_off;
  logic [63:0]              psq, trial;
  logic signed [WIDE_W-1:0] e_full;
  logic                     take;
  logic                     out_free;
  logic                     emit;

  assign dot = DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);

  always_comb begin
    px  = WIDE_W'(job.tx) - (WIDE_W'(p0) >>> FRAC_BITS);
    py  = WIDE_W'(job.ty) - (WIDE_W'(p1) >>> FRAC_BITS);
    pz  = WIDE_W'(job.tz) - (WIDE_W'(p2) >>> FRAC_BITS);
    abx = px[WIDE_W-1] ? WIDE_W'(-px) : WIDE_W'(px);
    aby = py[WIDE_W-1] ? WIDE_W'(-py) : WIDE_W'(py);
    abz = pz[WIDE_W-1] ? WIDE_W'(-pz) : WIDE_W'(pz);
    far_off = (abx >= WIDE_W'(job.radius)) || (aby >= WIDE_W'(job.radius)) ||
              (abz >= WIDE_W'(job.radius));
  end

  assign psq    = 64'(s0) + 64'(s1) + 64'(s2);
  assign trial  = root + sq_bit;
  assign e_full = WIDE_W'(axial) - signed'({40'd0, root[31:0]});

  assign take     = hit && (!any_hit || entry < best_distance);
  assign out_free = !result.valid || result.ready;
  assign emit     = (state == S_FIN) && job.last && out_free;
  assign pop      = (state == S_IDLE) && q_rd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hit           <= 1'b0;
      any_hit       <= 1'b0;
      best_distance <= '0;
      best_position <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          hit <= 1'b0;
          if (q_rd.valid) begin
            job   <= q_rd.job;
            state <= q_rd.job.skip ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          m0    <= job.tx * ray.dir_x;
          m1    <= job.ty * ray.dir_y;
          m2    <= job.tz * ray.dir_z;
          state <= S_SUM;
        end
        S_SUM: begin
          axial <= DW'(dot >>> FRAC_BITS);
          state <= S_PROJ;
        end
        S_PROJ: begin
          p0    <= ray.dir_x * axial;
          p1    <= ray.dir_y * axial;
          p2    <= ray.dir_z * axial;
          state <= S_PERP;
        end
        S_PERP: begin
          ax    <= abx[RAD_W-1:0];
          ay    <= aby[RAD_W-1:0];
          az    <= abz[RAD_W-1:0];
          state <= far_off ? S_FIN : S_SQ;
        end
        S_SQ: begin
          s0    <= ax * ax;
          s1    <= ay * ay;
          s2    <= az * az;
          rsq   <= job.radius * job.radius;
          state <= S_CMP;
        end
        S_CMP: begin
          rem    <= 64'(rsq) - psq;
          root   <= '0;
          sq_bit <= 64'd1 << 62;
          iter   <= '0;
          state  <= (psq >= 64'(rsq)) ? S_FIN : S_ROOT;
        end
        S_ROOT: begin
          // One result bit per cycle, two radicand bits consumed.
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + sq_bit;
          end else begin
            root <= root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          iter   <= iter + 1'b1;
          if (iter == 5'd31) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          hit <= 1'b1;
          if (e_full < 0) begin
            entry <= '0;
          end else if (e_full > signed'(WIDE_W'(DIST_MAX))) begin
            entry <= DIST_MAX;
          end else begin
            entry <= e_full[RAD_W-1:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!job.last) begin
            if (take) begin
              any_hit       <= 1'b1;
              best_distance <= entry;
              best_position <= job.index;
            end
            state <= S_IDLE;
          end else if (out_free) begin
            result.hit_found        <= any_hit || take;
            result.nearest_index    <= take ? job.index : (any_hit ? best_position : '0);
            result.nearest_distance <= take ? entry : (any_hit ? best_distance : '0);
            any_hit                 <= 1'b0;
            best_distance           <= '0;
            best_position           <= '0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/ray_sphere_nearest_pick.sv
// Top level of the ray/sphere nearest pick block.
//
//  channel   dir  kind          payload
//  cfg       in   write         index (0..5), data
//  sphere    in   valid/ready   center_x/y/z, sphere_radius, last_sphere
//  result    out  valid/ready   hit_found, nearest_index, nearest_distance
//
// A probed sphere runs the back-end sequencer through the 32-step square root;
// one rejected on offset or radius ends early; one past capacity skips to S_FIN.
// The front end accepts into a two-entry queue while the back works.
// Reset (rst, synchronous) restores the ray registers and empties run state.
// A last sphere waits in the back end while the result register is still full.
`timescale 1ns / 1ps
module ray_sphere_nearest_pick #(
  parameter int MAX_SPHERES = rsnp_pkg::MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = rsnp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rsnp_cfg_if.sink      cfg,
  rsnp_sphere_if.sink   sphere,
  rsnp_result_if.source result
);
  import rsnp_pkg::*;

  qwr_t q_wr;
  qrd_t q_rd;
  ray_t ray;
  logic q_ready;
  logic pop;

  // Classify: offset from eye, run position, capacity skip.
  rsnp_front #(
    .MAX_SPHERES (MAX_SPHERES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .sphere  (sphere),
    .q_ready (q_ready),
    .q_wr    (q_wr),
    .ray     (ray)
  );

  // Decouple the two ends.
  rsnp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .pop     (pop),
    .q_rd    (q_rd)
  );

  // Probe each sphere and track the nearest hit of the run.
  rsnp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .ray    (ray),
    .q_rd   (q_rd),
    .pop    (pop),
    .result (result)
  );

endmodule
